FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helpers for the encoder setpoint controller.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   // Field widths
   localparam int MV_W       = 15;
   localparam int MA_W       = 13;
   localparam int STEP_W     = 10;
   localparam int CPD_W      = 5;
   localparam int DEB_W      = 10;
   localparam int CNT_W      = 16;
   localparam int TIME_W     = 32;
   localparam int VCODE_W    = 11;
   localparam int LWORD_W    = 8;
   localparam int FAULT_W    = 3;
   localparam int STATUS_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // Datapath widths
   localparam int DET_W     = CNT_W + 1;            // signed detent count
   localparam int SUM_W     = DET_W + STEP_W + 1;   // signed product and sum
   localparam int DIV_CNT_W = $clog2(CNT_W);
   localparam int VRECIP_W  = 16;
   localparam int VPROD_W   = MV_W + VRECIP_W;
   localparam int LSUM_W    = MA_W + 1;
   localparam int LRECIP_W  = 13;
   localparam int LPROD_W   = LSUM_W + LRECIP_W;
   localparam int VQ_W      = VPROD_W - 19;
   localparam int LQ_W      = LPROD_W - 18;

   // Startup values
   localparam logic [MV_W-1:0] STARTUP_MILLIVOLTS = 15'd5000;
   localparam logic [MA_W-1:0] DEFAULT_LIMIT_MA   = 13'd1000;
   localparam logic            REVERSE_DIRECTION  = 1'b0;

   // Register reset values
   localparam logic [MV_W-1:0]   RST_MIN_MV   = 15'd800;
   localparam logic [MV_W-1:0]   RST_MAX_MV   = 15'd22000;
   localparam logic [STEP_W-1:0] RST_VSTEP    = 10'd100;
   localparam logic [MA_W-1:0]   RST_MIN_MA   = 13'd100;
   localparam logic [MA_W-1:0]   RST_MAX_MA   = 13'd6350;
   localparam logic [STEP_W-1:0] RST_LSTEP    = 10'd50;
   localparam logic [CPD_W-1:0]  RST_CPD      = 5'd4;
   localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 10'd30;

   // Code conversion constants
   localparam logic [MV_W-1:0]     VOLT_OFFSET_MV = 15'd800;
   // x / 10 == (x * 52429) >> 19 for x < 2^15
   localparam logic [VRECIP_W-1:0] DIV10_RECIP    = 16'd52429;
   localparam int                  DIV10_SHIFT    = 19;
   localparam logic [VQ_W-1:0]     VCODE_MAX      = 12'h7FF;
   localparam logic [LSUM_W-1:0]   LIMIT_ROUND    = 14'd25;
   // x / 50 == (x * 5243) >> 18 for x < 8217
   localparam logic [LRECIP_W-1:0] DIV50_RECIP    = 13'd5243;
   localparam int                  DIV50_SHIFT    = 18;
   localparam logic [LQ_W-1:0]     LCODE_MAX      = 9'd127;
   localparam logic [LWORD_W-1:0]  LIMIT_ENABLE   = 8'h80;
   localparam int                  FAULT_LSB      = 5;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_MV   = 3'd0,
      CSR_MAX_MV   = 3'd1,
      CSR_VSTEP    = 3'd2,
      CSR_MIN_MA   = 3'd3,
      CSR_MAX_MA   = 3'd4,
      CSR_LSTEP    = 3'd5,
      CSR_CPD      = 3'd6,
      CSR_DEBOUNCE = 3'd7
   } csr_index_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_MUL,
      S_ADD,
      S_APPLY,
      S_CLAMP,
      S_CODEMUL,
      S_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic div_step;
      logic mul;
      logic add;
      logic apply;
      logic code_clamp;
      logic code_mul;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic run;
      logic div_done;
   } status_type;

   // Clamp: below lo gives lo, otherwise above hi gives hi
   function automatic logic signed [SUM_W-1:0] clamp_range(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi);
      logic signed [SUM_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: steps the datapath through evaluate, divide, multiply,
// clamp and code conversion, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire esc_pkg::status_type status,
   output esc_pkg::cmd_type         cmd
);

   esc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         esc_pkg::S_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = esc_pkg::S_EVAL;
            end
         end
         esc_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.run ? esc_pkg::S_DIV : esc_pkg::S_CLAMP;
         end
         esc_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = esc_pkg::S_MUL;
            end
         end
         esc_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = esc_pkg::S_ADD;
         end
         esc_pkg::S_ADD: begin
            cmd.add  = 1'b1;
            state_in = esc_pkg::S_APPLY;
         end
         esc_pkg::S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = esc_pkg::S_CLAMP;
         end
         esc_pkg::S_CLAMP: begin
            cmd.code_clamp = 1'b1;
            state_in       = esc_pkg::S_CODEMUL;
         end
         esc_pkg::S_CODEMUL: begin
            cmd.code_mul = 1'b1;
            state_in     = esc_pkg::S_OUT;
         end
         esc_pkg::S_OUT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = esc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = esc_pkg::S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while occupied");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == esc_pkg::S_EVAL))
      else $error("accepted transaction not evaluated next cycle");

   a_run_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == esc_pkg::S_EVAL && status.run) |=> (state_ff == esc_pkg::S_DIV))
      else $error("knob path skipped the divider");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid without a load");
`endif

endmodule

`default_nettype wire

FILE: rtl/esc_datapath.sv
// ----------------------------------------------------------------------------
// esc_datapath
// Configuration registers, controller state, sample capture, iterative
// detent divider, step multiply, clamps, code conversion and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire esc_pkg::cmd_type                       cmd,
   output esc_pkg::status_type                         status,
   input  wire logic [esc_pkg::CNT_W-1:0]              req_encoder_count,
   input  wire logic                                   req_button_high,
   input  wire logic [esc_pkg::TIME_W-1:0]             req_time_ms,
   input  wire logic                                   req_output_on,
   input  wire logic                                   req_device_present,
   input  wire logic                                   req_status_valid,
   input  wire logic [esc_pkg::STATUS_W-1:0]           req_status_byte,
   input  wire logic                                   csr_write_enable,
   input  wire logic [esc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [esc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   output logic [esc_pkg::MV_W-1:0]                    rsp_target_mv,
   output logic [esc_pkg::MA_W-1:0]                    rsp_limit_ma,
   output logic [esc_pkg::VCODE_W-1:0]                 rsp_reference_code,
   output logic [esc_pkg::LWORD_W-1:0]                 rsp_limit_register,
   output logic                                        rsp_current_mode,
   output logic                                        rsp_write_voltage,
   output logic                                        rsp_write_limit,
   output logic                                        rsp_set_error,
   output logic [esc_pkg::FAULT_W-1:0]                 rsp_fault_flags
);

   // Configuration registers
   logic [esc_pkg::MV_W-1:0]   min_mv_ff, max_mv_ff;
   logic [esc_pkg::STEP_W-1:0] vstep_ff, lstep_ff;
   logic [esc_pkg::MA_W-1:0]   min_ma_ff, max_ma_ff;
   logic [esc_pkg::CPD_W-1:0]  cpd_ff;
   logic [esc_pkg::DEB_W-1:0]  deb_ff;

   // Controller state
   logic [esc_pkg::CNT_W-1:0]   ref_ff, ref_in;
   logic                        mode_ff, mode_in;
   logic [esc_pkg::MV_W-1:0]    target_ff, target_in;
   logic [esc_pkg::MA_W-1:0]    limit_ff, limit_in;
   logic                        raw_ff, raw_in;
   logic                        stable_ff, stable_in;
   logic [esc_pkg::TIME_W-1:0]  bct_ff, bct_in;
   logic [esc_pkg::FAULT_W-1:0] fault_ff, fault_in;
   logic                        was_on_ff, was_on_in;

   // Captured sample
   logic [esc_pkg::CNT_W-1:0]    count_ff;
   logic                         btn_ff;
   logic [esc_pkg::TIME_W-1:0]   now_ff;
   logic                         on_ff, present_ff, sval_ff;
   logic [esc_pkg::STATUS_W-1:0] sbyte_ff;

   // Per-transaction work registers
   logic                          wv_ff, wv_in, wl_ff, wl_in, err_ff, err_in;
   logic [esc_pkg::CNT_W-1:0]     dq_ff;
   logic [esc_pkg::CPD_W-1:0]     rem_ff;
   logic [esc_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                          sign_ff;
   logic signed [esc_pkg::SUM_W-1:0] prod_ff, sum_ff;
   logic                          det_nz_ff;
   logic [esc_pkg::MV_W-1:0]      vclamp_ff;
   logic [esc_pkg::MA_W-1:0]      mclamp_ff;
   logic                          vlow_ff;
   logic [esc_pkg::VPROD_W-1:0]   vprod_ff;
   logic [esc_pkg::LPROD_W-1:0]   lprod_ff;

   // Result register
   logic [esc_pkg::MV_W-1:0]    out_target_ff;
   logic [esc_pkg::MA_W-1:0]    out_limit_ff;
   logic [esc_pkg::VCODE_W-1:0] out_vcode_ff;
   logic [esc_pkg::LWORD_W-1:0] out_lword_ff;
   logic                        out_mode_ff, out_wv_ff, out_wl_ff, out_err_ff;
   logic [esc_pkg::FAULT_W-1:0] out_fault_ff;

   // Combinational helpers
   logic [esc_pkg::CPD_W-1:0]        cpd_eff;
   logic [esc_pkg::CNT_W-1:0]        delta, delta_mag;
   logic [esc_pkg::CPD_W:0]          trial;
   logic                             qbit;
   logic signed [esc_pkg::DET_W-1:0] det;
   logic signed [esc_pkg::STEP_W:0]  step_s;
   logic signed [esc_pkg::SUM_W-1:0] prod_full;
   logic signed [esc_pkg::SUM_W-1:0] clamp_v, clamp_m, knob_clamped;
   logic [esc_pkg::TIME_W-1:0]       elapsed;
   logic [esc_pkg::VQ_W-1:0]         vq;
   logic [esc_pkg::LQ_W-1:0]         lq;
   logic [esc_pkg::VCODE_W-1:0]      vcode;
   logic [esc_pkg::LWORD_W-1:0]      lword;
   logic [esc_pkg::LSUM_W-1:0]       lround;

   assign cpd_eff   = (cpd_ff == '0) ? esc_pkg::CPD_W'(1) : cpd_ff;
   assign delta     = count_ff - ref_ff;
   assign delta_mag = delta[esc_pkg::CNT_W-1] ? (~delta + 1'b1) : delta;

   // Knob runs only while the output stays on or on a failed power-on
   assign status.run = (on_ff == was_on_ff) ? on_ff : (on_ff && !present_ff);
   assign status.div_done = (div_cnt_ff == esc_pkg::DIV_CNT_W'(esc_pkg::CNT_W - 1));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_mv_ff <= esc_pkg::RST_MIN_MV;
         max_mv_ff <= esc_pkg::RST_MAX_MV;
         vstep_ff  <= esc_pkg::RST_VSTEP;
         min_ma_ff <= esc_pkg::RST_MIN_MA;
         max_ma_ff <= esc_pkg::RST_MAX_MA;
         lstep_ff  <= esc_pkg::RST_LSTEP;
         cpd_ff    <= esc_pkg::RST_CPD;
         deb_ff    <= esc_pkg::RST_DEBOUNCE;
      end else if (csr_write_enable) begin
         case (esc_pkg::csr_index_type'(csr_index))
            esc_pkg::CSR_MIN_MV:   min_mv_ff <= csr_write_data[esc_pkg::MV_W-1:0];
            esc_pkg::CSR_MAX_MV:   max_mv_ff <= csr_write_data[esc_pkg::MV_W-1:0];
            esc_pkg::CSR_VSTEP:    vstep_ff  <= csr_write_data[esc_pkg::STEP_W-1:0];
            esc_pkg::CSR_MIN_MA:   min_ma_ff <= csr_write_data[esc_pkg::MA_W-1:0];
            esc_pkg::CSR_MAX_MA:   max_ma_ff <= csr_write_data[esc_pkg::MA_W-1:0];
            esc_pkg::CSR_LSTEP:    lstep_ff  <= csr_write_data[esc_pkg::STEP_W-1:0];
            esc_pkg::CSR_CPD:      cpd_ff    <= csr_write_data[esc_pkg::CPD_W-1:0];
            esc_pkg::CSR_DEBOUNCE: deb_ff    <= csr_write_data[esc_pkg::DEB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Divider step: restoring, one quotient bit per cycle
   assign trial = {rem_ff, dq_ff[esc_pkg::CNT_W-1]};
   assign qbit  = (trial >= {1'b0, cpd_eff});

   // Signed detents and step product
   always_comb begin
      det = sign_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      if (esc_pkg::REVERSE_DIRECTION) begin
         det = -det;
      end
      step_s    = $signed({1'b0, (mode_ff ? lstep_ff : vstep_ff)});
      prod_full = det * step_s;
   end

   // Clamps of the knob sum and of the stored values
   always_comb begin
      if (mode_ff) begin
         knob_clamped = esc_pkg::clamp_range(sum_ff,
            $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, min_ma_ff}),
            $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, max_ma_ff}));
      end else begin
         knob_clamped = esc_pkg::clamp_range(sum_ff,
            $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, min_mv_ff}),
            $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, max_mv_ff}));
      end
      clamp_v = esc_pkg::clamp_range(
         $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, target_ff}),
         $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, min_mv_ff}),
         $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, max_mv_ff}));
      clamp_m = esc_pkg::clamp_range(
         $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, limit_ff}),
         $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, min_ma_ff}),
         $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, max_ma_ff}));
   end

   assign elapsed = now_ff - bct_ff;
   assign lround  = {1'b0, mclamp_ff} + esc_pkg::LIMIT_ROUND;

   // Final codes from the reciprocal products
   always_comb begin
      vq = vprod_ff[esc_pkg::VPROD_W-1:esc_pkg::DIV10_SHIFT];
      lq = lprod_ff[esc_pkg::LPROD_W-1:esc_pkg::DIV50_SHIFT];
      if (vlow_ff) begin
         vcode = '0;
      end else if (vq > esc_pkg::VCODE_MAX) begin
         vcode = esc_pkg::VCODE_MAX[esc_pkg::VCODE_W-1:0];
      end else begin
         vcode = vq[esc_pkg::VCODE_W-1:0];
      end
      if (lq > esc_pkg::LCODE_MAX) begin
         lword = esc_pkg::LIMIT_ENABLE | esc_pkg::LWORD_W'(esc_pkg::LCODE_MAX);
      end else begin
         lword = esc_pkg::LIMIT_ENABLE | esc_pkg::LWORD_W'(lq);
      end
   end

   // Next values of controller state and transaction flags
   always_comb begin
      ref_in    = ref_ff;
      mode_in   = mode_ff;
      target_in = target_ff;
      limit_in  = limit_ff;
      raw_in    = raw_ff;
      stable_in = stable_ff;
      bct_in    = bct_ff;
      fault_in  = fault_ff;
      was_on_in = was_on_ff;
      wv_in     = wv_ff;
      wl_in     = wl_ff;
      err_in    = err_ff;

      if (cmd.load) begin
         wv_in  = 1'b0;
         wl_in  = 1'b0;
         err_in = 1'b0;
      end

      // Output switch edges
      if (cmd.eval) begin
         if (on_ff != was_on_ff) begin
            was_on_in = on_ff;
            if (on_ff) begin
               if (present_ff) begin
                  target_in = esc_pkg::STARTUP_MILLIVOLTS;
                  limit_in  = esc_pkg::DEFAULT_LIMIT_MA;
                  mode_in   = 1'b0;
                  fault_in  = '0;
                  ref_in    = count_ff;
                  raw_in    = btn_ff;
                  stable_in = btn_ff;
                  bct_in    = now_ff;
                  wv_in     = 1'b1;
                  wl_in     = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end else begin
               target_in = esc_pkg::STARTUP_MILLIVOLTS;
               fault_in  = '0;
               wv_in     = present_ff;
            end
         end
         // Fault latch from a fresh status read
         if (status.run && present_ff && sval_ff) begin
            fault_in = fault_ff |
               sbyte_ff[esc_pkg::FAULT_LSB +: esc_pkg::FAULT_W];
         end
      end

      // Knob update and button debounce
      if (cmd.apply) begin
         if (det_nz_ff) begin
            ref_in   = sign_ff ? (count_ff + esc_pkg::CNT_W'(rem_ff))
                               : (count_ff - esc_pkg::CNT_W'(rem_ff));
            fault_in = '0;
            if (mode_ff) begin
               limit_in = knob_clamped[esc_pkg::MA_W-1:0];
               if (present_ff) wl_in = 1'b1; else err_in = 1'b1;
            end else begin
               target_in = knob_clamped[esc_pkg::MV_W-1:0];
               if (present_ff) wv_in = 1'b1; else err_in = 1'b1;
            end
         end
         if (btn_ff != raw_ff) begin
            bct_in = now_ff;
            raw_in = btn_ff;
         end else if (elapsed > esc_pkg::TIME_W'(deb_ff)) begin
            if (stable_ff && !btn_ff) begin
               mode_in = !mode_ff;
            end
            stable_in = btn_ff;
         end
      end
   end

   // Controller state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= '0;
         mode_ff   <= 1'b0;
         target_ff <= esc_pkg::STARTUP_MILLIVOLTS;
         limit_ff  <= esc_pkg::DEFAULT_LIMIT_MA;
         raw_ff    <= 1'b1;
         stable_ff <= 1'b1;
         bct_ff    <= '0;
         fault_ff  <= '0;
         was_on_ff <= 1'b0;
      end else begin
         ref_ff    <= ref_in;
         mode_ff   <= mode_in;
         target_ff <= target_in;
         limit_ff  <= limit_in;
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         bct_ff    <= bct_in;
         fault_ff  <= fault_in;
         was_on_ff <= was_on_in;
      end
   end

   // Sample capture, divider, arithmetic pipeline and result register
   always_ff @(posedge clock) begin
      wv_ff  <= wv_in;
      wl_ff  <= wl_in;
      err_ff <= err_in;
      if (cmd.load) begin
         count_ff   <= req_encoder_count;
         btn_ff     <= req_button_high;
         now_ff     <= req_time_ms;
         on_ff      <= req_output_on;
         present_ff <= req_device_present;
         sval_ff    <= req_status_valid;
         sbyte_ff   <= req_status_byte;
      end
      if (cmd.eval) begin
         dq_ff      <= delta_mag;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         sign_ff    <= delta[esc_pkg::CNT_W-1];
      end
      if (cmd.div_step) begin
         dq_ff      <= {dq_ff[esc_pkg::CNT_W-2:0], qbit};
         rem_ff     <= qbit ? trial[esc_pkg::CPD_W-1:0] - cpd_eff
                            : trial[esc_pkg::CPD_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.mul) begin
         prod_ff   <= prod_full;
         det_nz_ff <= (dq_ff != '0);
      end
      if (cmd.add) begin
         sum_ff <= prod_ff + (mode_ff
            ? $signed({{(esc_pkg::SUM_W-esc_pkg::MA_W){1'b0}}, limit_ff})
            : $signed({{(esc_pkg::SUM_W-esc_pkg::MV_W){1'b0}}, target_ff}));
      end
      if (cmd.code_clamp) begin
         vclamp_ff <= clamp_v[esc_pkg::MV_W-1:0];
         mclamp_ff <= clamp_m[esc_pkg::MA_W-1:0];
      end
      if (cmd.code_mul) begin
         vlow_ff  <= (vclamp_ff < esc_pkg::VOLT_OFFSET_MV);
         vprod_ff <= esc_pkg::VPROD_W'(vclamp_ff - esc_pkg::VOLT_OFFSET_MV)
                     * esc_pkg::VPROD_W'(esc_pkg::DIV10_RECIP);
         lprod_ff <= esc_pkg::LPROD_W'(lround) * esc_pkg::LPROD_W'(esc_pkg::DIV50_RECIP);
      end
      if (cmd.out_load) begin
         out_target_ff <= target_ff;
         out_limit_ff  <= limit_ff;
         out_vcode_ff  <= vcode;
         out_lword_ff  <= lword;
         out_mode_ff   <= mode_ff;
         out_wv_ff     <= wv_ff;
         out_wl_ff     <= wl_ff;
         out_err_ff    <= err_ff;
         out_fault_ff  <= fault_ff;
      end
   end

   assign rsp_target_mv      = out_target_ff;
   assign rsp_limit_ma       = out_limit_ff;
   assign rsp_reference_code = out_vcode_ff;
   assign rsp_limit_register = out_lword_ff;
   assign rsp_current_mode   = out_mode_ff;
   assign rsp_write_voltage  = out_wv_ff;
   assign rsp_write_limit    = out_wl_ff;
   assign rsp_set_error      = out_err_ff;
   assign rsp_fault_flags    = out_fault_ff;

endmodule

`default_nettype wire

FILE: rtl/encoder_setpoint_controller.sv
// From input acceptance the knob path runs evaluate, the bit-serial detent divider,
// multiply, add, apply, clamp, code multiply and output; otherwise evaluate goes
// straight to clamp, code multiply and output. One transaction is processed at a time;
// a finished result waits in the output state while the output register is occupied;
// the next transaction is accepted while a result still waits in the output register.
// Reset (synchronous, active high) restores registers, setpoints and button state.
// ----------------------------------------------------------------------------
// encoder_setpoint_controller
// Poll-driven setpoint controller: encoder detents step the voltage target
// or current limit, a debounced press toggles the mode, faults are latched.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_setpoint_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [esc_pkg::CNT_W-1:0]        req_encoder_count,
   input  wire logic                             req_button_high,
   input  wire logic [esc_pkg::TIME_W-1:0]       req_time_ms,
   input  wire logic                             req_output_on,
   input  wire logic                             req_device_present,
   input  wire logic                             req_status_valid,
   input  wire logic [esc_pkg::STATUS_W-1:0]     req_status_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [esc_pkg::MV_W-1:0]              rsp_target_mv,
   output logic [esc_pkg::MA_W-1:0]              rsp_limit_ma,
   output logic [esc_pkg::VCODE_W-1:0]           rsp_reference_code,
   output logic [esc_pkg::LWORD_W-1:0]           rsp_limit_register,
   output logic                                  rsp_current_mode,
   output logic                                  rsp_write_voltage,
   output logic                                  rsp_write_limit,
   output logic                                  rsp_set_error,
   output logic [esc_pkg::FAULT_W-1:0]           rsp_fault_flags,
   input  wire logic                             csr_write_enable,
   input  wire logic [esc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [esc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   esc_pkg::cmd_type    cmd;
   esc_pkg::status_type status;

   // Sequencer
   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   esc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_encoder_count  (req_encoder_count),
      .req_button_high    (req_button_high),
      .req_time_ms        (req_time_ms),
      .req_output_on      (req_output_on),
      .req_device_present (req_device_present),
      .req_status_valid   (req_status_valid),
      .req_status_byte    (req_status_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_target_mv      (rsp_target_mv),
      .rsp_limit_ma       (rsp_limit_ma),
      .rsp_reference_code (rsp_reference_code),
      .rsp_limit_register (rsp_limit_register),
      .rsp_current_mode   (rsp_current_mode),
      .rsp_write_voltage  (rsp_write_voltage),
      .rsp_write_limit    (rsp_write_limit),
      .rsp_set_error      (rsp_set_error),
      .rsp_fault_flags    (rsp_fault_flags)
   );

endmodule

`default_nettype wire

FILE: tb/sv/encoder_setpoint_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_setpoint_controller_tb
// Self-checking bench for the encoder setpoint controller. Poll samples are
// driven on the req_ channel and each result on the rsp_ channel is checked
// against a behavioral predictor of detent stepping, clamping, code
// conversion, button debounce, fault latching and output power cycling.
// Directed samples come first, then randomized samples under several
// register settings, with random stalls on both channels except in the last run.
// ----------------------------------------------------------------------------

module encoder_setpoint_controller_tb;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 11;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int VOLT_LSB_MV  = 10;
   localparam int LIMIT_LSB_MA = 50;

   typedef struct packed {
      logic [esc_pkg::CNT_W-1:0]    encoder_count;
      logic                         button_high;
      logic [esc_pkg::TIME_W-1:0]   time_ms;
      logic                         output_on;
      logic                         device_present;
      logic                         status_valid;
      logic [esc_pkg::STATUS_W-1:0] status_byte;
   } poll_sample_type;

   typedef struct packed {
      logic [esc_pkg::MV_W-1:0]    target_mv;
      logic [esc_pkg::MA_W-1:0]    limit_ma;
      logic [esc_pkg::VCODE_W-1:0] reference_code;
      logic [esc_pkg::LWORD_W-1:0] limit_register;
      logic                        current_mode;
      logic                        write_voltage;
      logic                        write_limit;
      logic                        set_error;
      logic [esc_pkg::FAULT_W-1:0] fault_flags;
   } setpoint_result_type;

   // DUT connections
   logic                           clock;
   logic                           reset              = 1'b1;
   logic                           req_valid          = 1'b0;
   logic                           req_ready;
   logic [esc_pkg::CNT_W-1:0]      req_encoder_count  = '0;
   logic                           req_button_high    = 1'b1;
   logic [esc_pkg::TIME_W-1:0]     req_time_ms        = '0;
   logic                           req_output_on      = 1'b0;
   logic                           req_device_present = 1'b0;
   logic                           req_status_valid   = 1'b0;
   logic [esc_pkg::STATUS_W-1:0]   req_status_byte    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready          = 1'b0;
   logic [esc_pkg::MV_W-1:0]       rsp_target_mv;
   logic [esc_pkg::MA_W-1:0]       rsp_limit_ma;
   logic [esc_pkg::VCODE_W-1:0]    rsp_reference_code;
   logic [esc_pkg::LWORD_W-1:0]    rsp_limit_register;
   logic                           rsp_current_mode;
   logic                           rsp_write_voltage;
   logic                           rsp_write_limit;
   logic                           rsp_set_error;
   logic [esc_pkg::FAULT_W-1:0]    rsp_fault_flags;
   logic                           csr_write_enable   = 1'b0;
   logic [esc_pkg::CSR_IDX_W-1:0]  csr_index          = '0;
   logic [esc_pkg::CSR_DATA_W-1:0] csr_write_data     = '0;

   // Bench bookkeeping
   poll_sample_type     poll_queue[$];
   setpoint_result_type expected_setpoints[$];
   int  samples_queued  = 0;
   int  results_seen    = 0;
   int  mismatches      = 0;
   int  cycle_count     = 0;
   int  send_gap        = 0;
   int  ready_stall     = 0;
   bit  req_fire        = 1'b0;
   bit  idle_on         = 1'b1;

   // Predictor copy of the registers
   logic [esc_pkg::MV_W-1:0]   cfg_min_mv;
   logic [esc_pkg::MV_W-1:0]   cfg_max_mv;
   logic [esc_pkg::STEP_W-1:0] cfg_vstep;
   logic [esc_pkg::MA_W-1:0]   cfg_min_ma;
   logic [esc_pkg::MA_W-1:0]   cfg_max_ma;
   logic [esc_pkg::STEP_W-1:0] cfg_lstep;
   logic [esc_pkg::CPD_W-1:0]  cfg_cpd;
   logic [esc_pkg::DEB_W-1:0]  cfg_debounce;

   // Predictor copy of the controller state
   logic [esc_pkg::CNT_W-1:0]   enc_ref;
   logic                        mode_cur;
   logic [esc_pkg::MV_W-1:0]    tgt_mv;
   logic [esc_pkg::MA_W-1:0]    lim_ma;
   logic                        raw_btn;
   logic                        stable_btn;
   logic [esc_pkg::TIME_W-1:0]  btn_time;
   logic [esc_pkg::FAULT_W-1:0] faults;
   logic                        was_on;

   // Stimulus generator state
   logic [esc_pkg::CNT_W-1:0]  g_count   = '0;
   logic [esc_pkg::TIME_W-1:0] g_time    = '0;
   logic                       g_btn     = 1'b1;
   logic                       g_on      = 1'b1;

   encoder_setpoint_controller u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_encoder_count  (req_encoder_count),
      .req_button_high    (req_button_high),
      .req_time_ms        (req_time_ms),
      .req_output_on      (req_output_on),
      .req_device_present (req_device_present),
      .req_status_valid   (req_status_valid),
      .req_status_byte    (req_status_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_target_mv      (rsp_target_mv),
      .rsp_limit_ma       (rsp_limit_ma),
      .rsp_reference_code (rsp_reference_code),
      .rsp_limit_register (rsp_limit_register),
      .rsp_current_mode   (rsp_current_mode),
      .rsp_write_voltage  (rsp_write_voltage),
      .rsp_write_limit    (rsp_write_limit),
      .rsp_set_error      (rsp_set_error),
      .rsp_fault_flags    (rsp_fault_flags),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Below lo gives lo, otherwise above hi gives hi (crossed bounds included)
   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [esc_pkg::VCODE_W-1:0] reference_code_of(
      input logic [esc_pkg::MV_W-1:0] mv_in);
      int mv;
      int code;
      mv = clamp_int(int'(mv_in), int'(cfg_min_mv), int'(cfg_max_mv));
      if (mv < int'(esc_pkg::VOLT_OFFSET_MV)) return '0;
      code = clamp_int((mv - int'(esc_pkg::VOLT_OFFSET_MV)) / VOLT_LSB_MV, 0,
                       int'(esc_pkg::VCODE_MAX));
      return code[esc_pkg::VCODE_W-1:0];
   endfunction

   function automatic logic [esc_pkg::LWORD_W-1:0] limit_word_of(
      input logic [esc_pkg::MA_W-1:0] ma_in);
      int ma;
      int code;
      ma = clamp_int(int'(ma_in), int'(cfg_min_ma), int'(cfg_max_ma));
      code = clamp_int((ma + int'(esc_pkg::LIMIT_ROUND)) / LIMIT_LSB_MA, 0,
                       int'(esc_pkg::LCODE_MAX));
      return esc_pkg::LIMIT_ENABLE | code[esc_pkg::LWORD_W-1:0];
   endfunction

   task automatic reset_setpoint_state();
      cfg_min_mv   = esc_pkg::RST_MIN_MV;
      cfg_max_mv   = esc_pkg::RST_MAX_MV;
      cfg_vstep    = esc_pkg::RST_VSTEP;
      cfg_min_ma   = esc_pkg::RST_MIN_MA;
      cfg_max_ma   = esc_pkg::RST_MAX_MA;
      cfg_lstep    = esc_pkg::RST_LSTEP;
      cfg_cpd      = esc_pkg::RST_CPD;
      cfg_debounce = esc_pkg::RST_DEBOUNCE;
      enc_ref      = '0;
      mode_cur     = 1'b0;
      tgt_mv       = esc_pkg::STARTUP_MILLIVOLTS;
      lim_ma       = esc_pkg::DEFAULT_LIMIT_MA;
      raw_btn      = 1'b1;
      stable_btn   = 1'b1;
      btn_time     = '0;
      faults       = '0;
      was_on       = 1'b0;
   endtask

   // Advance the predicted state by one poll sample and build its result
   task automatic step_setpoint(input poll_sample_type s, output setpoint_result_type r);
      int cpd;
      int delta;
      int det;
      int v;
      logic [esc_pkg::CNT_W-1:0]  diff;
      logic [esc_pkg::TIME_W-1:0] held;
      logic wv;
      logic wl;
      logic err;
      logic run;
      wv  = 1'b0;
      wl  = 1'b0;
      err = 1'b0;
      run = 1'b1;

      // Output switch edges
      if (s.output_on != was_on) begin
         was_on = s.output_on;
         if (s.output_on) begin
            if (s.device_present) begin
               tgt_mv     = esc_pkg::STARTUP_MILLIVOLTS;
               lim_ma     = esc_pkg::DEFAULT_LIMIT_MA;
               mode_cur   = 1'b0;
               faults     = '0;
               enc_ref    = s.encoder_count;
               raw_btn    = s.button_high;
               stable_btn = s.button_high;
               btn_time   = s.time_ms;
               wv         = 1'b1;
               wl         = 1'b1;
               run        = 1'b0;
            end else begin
               err = 1'b1;
            end
         end else begin
            tgt_mv = esc_pkg::STARTUP_MILLIVOLTS;
            faults = '0;
            wv     = s.device_present;
            run    = 1'b0;
         end
      end else if (!s.output_on) begin
         run = 1'b0;
      end

      if (run) begin
         // Whole detents, truncated toward zero; remainder stays in the reference
         cpd   = (cfg_cpd == '0) ? 1 : int'(cfg_cpd);
         diff  = s.encoder_count - enc_ref;
         delta = int'($signed(diff));
         det   = delta / cpd;

         if (s.device_present && s.status_valid)
            faults = faults | 3'(s.status_byte >> esc_pkg::FAULT_LSB);

         if (det != 0) begin
            enc_ref = enc_ref + 16'(det * cpd);
            if (esc_pkg::REVERSE_DIRECTION) det = -det;
            faults = '0;
            if (mode_cur) begin
               v = int'(lim_ma) + det * int'(cfg_lstep);
               v = clamp_int(v, int'(cfg_min_ma), int'(cfg_max_ma));
               lim_ma = v[esc_pkg::MA_W-1:0];
               if (s.device_present) wl = 1'b1; else err = 1'b1;
            end else begin
               v = int'(tgt_mv) + det * int'(cfg_vstep);
               v = clamp_int(v, int'(cfg_min_mv), int'(cfg_max_mv));
               tgt_mv = v[esc_pkg::MV_W-1:0];
               if (s.device_present) wv = 1'b1; else err = 1'b1;
            end
         end

         // Button debounce; a settled press toggles the mode
         if (s.button_high != raw_btn) begin
            btn_time = s.time_ms;
            raw_btn  = s.button_high;
         end
         held = s.time_ms - btn_time;
         if (held > {22'd0, cfg_debounce}) begin
            if (stable_btn && !s.button_high) mode_cur = !mode_cur;
            stable_btn = s.button_high;
         end
      end

      r.target_mv      = tgt_mv;
      r.limit_ma       = lim_ma;
      r.reference_code = reference_code_of(tgt_mv);
      r.limit_register = limit_word_of(lim_ma);
      r.current_mode   = mode_cur;
      r.write_voltage  = wv;
      r.write_limit    = wl;
      r.set_error      = err;
      r.fault_flags    = faults;
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents queued samples, random gaps between transactions
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      poll_sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (poll_queue.size() != 0) begin
            next_sample = poll_queue.pop_front();
            req_encoder_count  <= next_sample.encoder_count;
            req_button_high    <= next_sample.button_high;
            req_time_ms        <= next_sample.time_ms;
            req_output_on      <= next_sample.output_on;
            req_device_present <= next_sample.device_present;
            req_status_valid   <= next_sample.status_valid;
            req_status_byte    <= next_sample.status_byte;
            req_valid          <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure in short bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_stall > 0) begin
         ready_stall = ready_stall - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         ready_stall = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on request transactions, check result transactions
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      poll_sample_type     taken;
      setpoint_result_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            taken.encoder_count  = req_encoder_count;
            taken.button_high    = req_button_high;
            taken.time_ms        = req_time_ms;
            taken.output_on      = req_output_on;
            taken.device_present = req_device_present;
            taken.status_valid   = req_status_valid;
            taken.status_byte    = req_status_byte;
            step_setpoint(taken, want);
            expected_setpoints.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen = results_seen + 1;
            if (expected_setpoints.size() == 0) begin
               $display("%0t: unexpected result, expected none actual target_mv %0d",
                        $time, rsp_target_mv);
               mismatches = mismatches + 1;
            end else begin
               want = expected_setpoints.pop_front();
               check_field("target_mv", want.target_mv, rsp_target_mv);
               check_field("limit_ma", want.limit_ma, rsp_limit_ma);
               check_field("reference_code", want.reference_code, rsp_reference_code);
               check_field("limit_register", want.limit_register, rsp_limit_register);
               check_field("current_mode", want.current_mode, rsp_current_mode);
               check_field("write_voltage", want.write_voltage, rsp_write_voltage);
               check_field("write_limit", want.write_limit, rsp_write_limit);
               check_field("set_error", want.set_error, rsp_set_error);
               check_field("fault_flags", want.fault_flags, rsp_fault_flags);
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout waiting for results", $time);
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_sample(input logic [esc_pkg::CNT_W-1:0] count, input logic btn,
                               input logic [esc_pkg::TIME_W-1:0] now, input logic on,
                               input logic present, input logic sval,
                               input logic [esc_pkg::STATUS_W-1:0] sbyte);
      poll_sample_type s;
      s.encoder_count  = count;
      s.button_high    = btn;
      s.time_ms        = now;
      s.output_on      = on;
      s.device_present = present;
      s.status_valid   = sval;
      s.status_byte    = sbyte;
      poll_queue.push_back(s);
      samples_queued = samples_queued + 1;
   endtask

   // Mostly realistic knob turning and button use, with jumps and power cycles
   task automatic queue_random_samples(input int n);
      int pick;
      logic present;
      logic sval;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (g_on && pick < 2) g_on = 1'b0;
         else if (!g_on && pick < 40) g_on = 1'b1;

         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            g_count = g_count;
         end else if (pick < 80) begin
            g_count = g_count + 16'(int'($urandom_range(0, 48)) - 24);
         end else if (pick < 93) begin
            g_count = g_count + 16'(int'($urandom_range(0, 4000)) - 2000);
         end else begin
            g_count = 16'($urandom);
         end

         pick = $urandom_range(0, 99);
         if (pick < 85) g_time = g_time + $urandom_range(1, 60);
         else if (pick < 97) g_time = g_time + $urandom_range(0, 2000);
         else g_time = $urandom;

         if ($urandom_range(0, 9) == 0) g_btn = !g_btn;
         present = ($urandom_range(0, 19) != 0);
         sval    = ($urandom_range(0, 6) == 0);
         queue_sample(g_count, g_btn, g_time, g_on, present, sval, 8'($urandom));
      end
   endtask

   // Wait until every queued sample has produced its result
   task automatic wait_for_results();
      @(negedge clock);
      while (results_seen != samples_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input esc_pkg::csr_index_type idx, input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[esc_pkg::CSR_DATA_W-1:0];
      case (idx)
         esc_pkg::CSR_MIN_MV:   cfg_min_mv   = value[esc_pkg::MV_W-1:0];
         esc_pkg::CSR_MAX_MV:   cfg_max_mv   = value[esc_pkg::MV_W-1:0];
         esc_pkg::CSR_VSTEP:    cfg_vstep    = value[esc_pkg::STEP_W-1:0];
         esc_pkg::CSR_MIN_MA:   cfg_min_ma   = value[esc_pkg::MA_W-1:0];
         esc_pkg::CSR_MAX_MA:   cfg_max_ma   = value[esc_pkg::MA_W-1:0];
         esc_pkg::CSR_LSTEP:    cfg_lstep    = value[esc_pkg::STEP_W-1:0];
         esc_pkg::CSR_CPD:      cfg_cpd      = value[esc_pkg::CPD_W-1:0];
         esc_pkg::CSR_DEBOUNCE: cfg_debounce = value[esc_pkg::DEB_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input int min_mv, input int max_mv, input int vstep,
                                input int min_ma, input int max_ma, input int lstep,
                                input int cpd, input int deb);
      csr_write(esc_pkg::CSR_MIN_MV, min_mv);
      csr_write(esc_pkg::CSR_MAX_MV, max_mv);
      csr_write(esc_pkg::CSR_VSTEP, vstep);
      csr_write(esc_pkg::CSR_MIN_MA, min_ma);
      csr_write(esc_pkg::CSR_MAX_MA, max_ma);
      csr_write(esc_pkg::CSR_LSTEP, lstep);
      csr_write(esc_pkg::CSR_CPD, cpd);
      csr_write(esc_pkg::CSR_DEBOUNCE, deb);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      reset_setpoint_state();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: power-on, detents with remainder, faults, mode toggle
      queue_sample(16'h1234, 1'b1, 32'd100, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1238, 1'b1, 32'd110, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h122F, 1'b1, 32'd120, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1230, 1'b1, 32'd130, 1'b1, 1'b1, 1'b1, 8'hE0);
      // status and knob in one sample: latched, then cleared
      queue_sample(16'h1234, 1'b1, 32'd140, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_sample(16'h1234, 1'b0, 32'd150, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1234, 1'b0, 32'd181, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1234, 1'b1, 32'd190, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1234, 1'b1, 32'd230, 1'b1, 1'b1, 1'b0, 8'h00);
      // largest positive and negative deltas in current mode
      queue_sample(16'h9233, 1'b1, 32'd240, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h1230, 1'b1, 32'd250, 1'b1, 1'b1, 1'b0, 8'h00);
      // knob with converter absent
      queue_sample(16'h1240, 1'b1, 32'd260, 1'b1, 1'b0, 1'b1, 8'hE0);
      // power-off with converter, then output stays off
      queue_sample(16'h0000, 1'b1, 32'd270, 1'b0, 1'b1, 1'b0, 8'h00);
      queue_sample(16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 8'hFF);
      // power-on without converter, power-off without converter
      queue_sample(16'h0100, 1'b1, 32'd280, 1'b1, 1'b0, 1'b1, 8'hA0);
      queue_sample(16'h0100, 1'b1, 32'd290, 1'b0, 1'b0, 1'b0, 8'h00);
      // power-on with the button held, counter and tick about to wrap
      queue_sample(16'hFFFF, 1'b0, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h0003, 1'b0, 32'h0000_0010, 1'b1, 1'b1, 1'b1, 8'h40);
      queue_sample(16'h0003, 1'b1, 32'h0000_0020, 1'b1, 1'b1, 1'b1, 8'h20);
      queue_sample(16'h0002, 1'b1, 32'h0000_0040, 1'b1, 1'b1, 1'b1, 8'h1F);
      queue_sample(16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 8'h00);
      // voltage clamps at both bounds
      queue_sample(16'h8002, 1'b1, 32'h0000_0100, 1'b1, 1'b1, 1'b0, 8'h00);
      queue_sample(16'h0002, 1'b1, 32'h0000_0110, 1'b1, 1'b1, 1'b0, 8'h00);
      wait_for_results();

      // Reset settings; the sender holds off until all results are back
      @(posedge clock);
      queue_random_samples(120);
      wait_for_results();
      @(posedge clock);
      queue_random_samples(130);
      wait_for_results();

      // Widest bounds, steps of 1000, one count per detent, no debounce
      load_settings(0, 32767, 1000, 0, 8191, 1000, 1, 0);
      @(posedge clock);
      queue_random_samples(200);
      wait_for_results();

      // Crossed bounds, steps of 1, 16 counts per detent, debounce of 1000
      load_settings(20000, 1000, 1, 5000, 200, 1, 16, 1000);
      @(posedge clock);
      queue_random_samples(200);
      wait_for_results();

      // Zero counts per detent acts as one
      load_settings(1000, 30000, 250, 50, 8000, 7, 0, 500);
      @(posedge clock);
      queue_random_samples(150);
      wait_for_results();

      // Random settings
      repeat (3) begin
         load_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(1, 1000), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom_range(1, 1000),
                       $urandom_range(0, 16), $urandom_range(0, 1000));
         @(posedge clock);
         queue_random_samples(200);
         wait_for_results();
      end

      // Back to reset values, both sides at full rate
      load_settings(esc_pkg::RST_MIN_MV, esc_pkg::RST_MAX_MV, esc_pkg::RST_VSTEP,
                    esc_pkg::RST_MIN_MA, esc_pkg::RST_MAX_MA, esc_pkg::RST_LSTEP,
                    esc_pkg::RST_CPD, esc_pkg::RST_DEBOUNCE);
      @(posedge clock);
      idle_on = 1'b0;
      queue_random_samples(200);
      wait_for_results();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_setpoints.size() != 0) begin
         $display("%0t: results missing, expected %0d more actual 0",
                  $time, expected_setpoints.size());
         mismatches = mismatches + 1;
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/esc_pkg.sv
rtl/esc_ctrl.sv
rtl/esc_datapath.sv
rtl/encoder_setpoint_controller.sv
tb/sv/encoder_setpoint_controller_tb.sv
